>>> hdl/ttp_pkg.sv
// ttp_pkg: widths, codes and shared types for the thermal trend predictor.
// No dependencies; imported by ttp_div, thermal_trend_predictor and the bench.
`timescale 1ns / 1ps
package ttp_pkg;

   localparam int DEF_NUM_ZONES = 4;
   localparam int DEF_WINDOW    = 16;

   localparam int SAMPLE_W = 19;   // signed millidegrees
   localparam int PRED_W   = 18;
   localparam int DEG_W    = 9;    // signed whole degrees
   localparam int LVL_W    = 8;
   localparam int HOR_W    = 10;
   localparam int CSR_W    = 10;

   // accumulator widths sized for the largest window (64)
   localparam int SX_W   = 12;
   localparam int SXX_W  = 17;
   localparam int SY_W   = 25;
   localparam int SXY_W  = 32;
   localparam int NUM_W  = 38;
   localparam int DEN_W  = 26;
   localparam int T_W    = 19;
   localparam int TOP_W  = 58;
   localparam int DVD_W  = 57;
   localparam int DVS_W  = 32;
   localparam int MUL_W  = 32;
   localparam int NUM_LO = 19;    // low part of num for split product

   localparam int PRED_MAX    = 150000;
   localparam int SLOPE_LIMIT = 100;
   localparam int MDEG_PER_DEG = 1000;
   // floor(m / 1000) = (m * RECIP_1000) >> RECIP_SHIFT for m <= 2^18
   localparam int RECIP_1000  = 268436;
   localparam int RECIP_SHIFT = 28;

   // register indexes
   localparam logic [1:0] REG_WARN     = 2'd0;
   localparam logic [1:0] REG_THROTTLE = 2'd1;
   localparam logic [1:0] REG_CRITICAL = 2'd2;
   localparam logic [1:0] REG_HORIZON  = 2'd3;

   localparam logic [1:0] TREND_STABLE  = 2'd0;
   localparam logic [1:0] TREND_RISING  = 2'd1;
   localparam logic [1:0] TREND_FALLING = 2'd2;

   localparam logic [1:0] LEVEL_COOL     = 2'd0;
   localparam logic [1:0] LEVEL_WARM     = 2'd1;
   localparam logic [1:0] LEVEL_HOT      = 2'd2;
   localparam logic [1:0] LEVEL_CRITICAL = 2'd3;

   // multiply sequence steps
   localparam logic [3:0] MS_NSXY  = 4'd0;
   localparam logic [3:0] MS_NUM   = 4'd1;
   localparam logic [3:0] MS_NSXX  = 4'd2;
   localparam logic [3:0] MS_DEN   = 4'd3;
   localparam logic [3:0] MS_LIM   = 4'd4;
   localparam logic [3:0] MS_TREND = 4'd5;
   localparam logic [3:0] MS_TOP0  = 4'd6;
   localparam logic [3:0] MS_TOPLO = 4'd7;
   localparam logic [3:0] MS_TOPHI = 4'd8;
   localparam logic [3:0] MS_DVS   = 4'd9;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_WRITE  = 8'b0000_0010,
      ST_ACC    = 8'b0000_0100,
      ST_MUL    = 8'b0000_1000,
      ST_DIV    = 8'b0001_0000,
      ST_SINGLE = 8'b0010_0000,
      ST_SCAN   = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_sts_type;

endpackage

>>> hdl/ttp_div.sv
// ttp_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on ttp_pkg for widths and the control/status structs.
`timescale 1ns / 1ps
module ttp_div
   import ttp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_ctl_type ctl,
   output div_sts_type sts
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] q_ff, q_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   rem_sh;
   logic [DVS_W:0]   diff;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, q_ff[DVD_W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      if (ctl.start) begin
         q_in    = ctl.dividend;
         rem_in  = '0;
         dvs_in  = ctl.divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DVS_W]) begin
            rem_in = diff[DVS_W-1:0];
            q_in   = {q_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DVS_W-1:0];
            q_in   = {q_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign sts.done     = done_ff;
   assign sts.quotient = q_ff;

endmodule

>>> hdl/thermal_trend_predictor.sv
// thermal_trend_predictor: per-zone sliding-window least-squares trend and prediction.
// Depends on ttp_pkg and ttp_div.
// Sequence: with one sample held, a write, a single-sample prediction and the zone scan;
// else a write, the window walk, 10 multiply steps, the bit-serial divide and the NUM_ZONES
// scan, the divider dominating. Next word taken the cycle after the result is taken.
// Sync reset clears fill counts, write slots and zone degrees and loads register defaults; window not cleared.
`timescale 1ns / 1ps
module thermal_trend_predictor
   import ttp_pkg::*;
#(
   parameter int NUM_ZONES = DEF_NUM_ZONES,
   parameter int WINDOW    = DEF_WINDOW
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_zone_index,
   input  logic [SAMPLE_W-1:0] req_sample_mdeg,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_trend,
   output logic [PRED_W-1:0]   rsp_predicted_mdeg,
   output logic [1:0]          rsp_overall_level,
   input  logic                csr_wen,
   input  logic [1:0]          csr_index,
   input  logic [CSR_W-1:0]    csr_wdata
);

   localparam int ZIDX_W = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
   localparam int ZX_W   = (ZIDX_W > 2) ? ZIDX_W : 2;
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SLOT_W = $clog2(WINDOW);
   localparam int DEPTH  = NUM_ZONES * WINDOW;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SQ_W   = 2 * CNT_W;
   localparam int FX_W   = 12;

   // configuration
   logic [LVL_W-1:0] warn_ff, thr_ff, crit_ff;
   logic [HOR_W-1:0] hor_ff;

   // per-zone state
   logic [CNT_W-1:0]        fill_ff [NUM_ZONES];
   logic [SLOT_W-1:0]       slot_ff [NUM_ZONES];
   logic signed [DEG_W-1:0] deg_ff  [NUM_ZONES];

   // window memory
   logic signed [SAMPLE_W-1:0] mem [DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic                       mem_wen, mem_ren;
   logic [AW-1:0]              mem_waddr, mem_raddr;

   state_type state_ff, state_in;
   logic [ZIDX_W-1:0]          zone_ff, zone_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [CNT_W-1:0]           n_ff, n_in;
   logic [SLOT_W-1:0]          rd_slot_ff, rd_slot_in;
   logic [CNT_W-1:0]           rd_cnt_ff, rd_cnt_in;
   logic                       pv_ff, pv_in;
   logic [CNT_W-1:0]           x_ff, x_in;
   logic [SQ_W-1:0]            sq_ff, sq_in;
   logic [SX_W-1:0]            sx_ff, sx_in;
   logic [SXX_W-1:0]           sxx_ff, sxx_in;
   logic signed [SY_W-1:0]     sy_ff, sy_in;
   logic signed [SXY_W-1:0]    sxy_ff, sxy_in;
   logic signed [63:0]         tmp_ff, tmp_in;
   logic signed [NUM_W-1:0]    num_ff, num_in;
   logic signed [DEN_W-1:0]    den_ff, den_in;
   logic signed [NUM_W-1:0]    lim_ff, lim_in;
   logic signed [T_W-1:0]      t_ff, t_in;
   logic signed [TOP_W-1:0]    top_ff, top_in;
   logic                       neg_ff, neg_in;
   logic [3:0]                 step_ff, step_in;
   logic [ZIDX_W-1:0]          scan_ff, scan_in;
   logic signed [DEG_W-1:0]    hot_ff, hot_in;
   logic signed [DEG_W-1:0]    cur_deg_ff, cur_deg_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 trend_ff, trend_in;
   logic [PRED_W-1:0]          pred_ff, pred_in;
   logic [1:0]                 level_ff, level_in;

   // shared multiplier
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [63:0]      prod;
   assign prod = mul_a * mul_b;

   div_ctl_type div_ctl;
   div_sts_type div_sts;

   ttp_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   // zone update strobes
   logic                    zupd;
   logic [CNT_W-1:0]        zfill_new;
   logic [SLOT_W-1:0]       zslot_new;
   logic signed [DEG_W-1:0] zdeg_new;

   logic [ZX_W-1:0]         zone_ext;
   logic [AW-1:0]           base;
   logic [SAMPLE_W-1:0]     mag;
   logic [9:0]              deg_q;
   logic [FX_W-1:0]         fx;
   logic signed [TOP_W-1:0] top_abs;
   logic signed [DEG_W-1:0] hot_new;

   assign zone_ext  = ZX_W'(req_zone_index);
   assign base      = AW'(32'(zone_ff) * WINDOW);
   assign mag       = sample_ff[SAMPLE_W-1] ? SAMPLE_W'(-sample_ff) : SAMPLE_W'(sample_ff);
   assign deg_q     = 10'(prod >>> RECIP_SHIFT);
   assign fx        = FX_W'(n_ff) - FX_W'(1) + FX_W'(hor_ff);
   assign top_abs   = top_ff[TOP_W-1] ? -top_ff : top_ff;
   assign hot_new   = (deg_ff[scan_ff] > hot_ff) ? deg_ff[scan_ff] : hot_ff;

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_trend          = trend_ff;
   assign rsp_predicted_mdeg = pred_ff;
   assign rsp_overall_level  = level_ff;

   always_comb begin
      state_in     = state_ff;
      zone_in      = zone_ff;
      sample_in    = sample_ff;
      n_in         = n_ff;
      rd_slot_in   = rd_slot_ff;
      rd_cnt_in    = rd_cnt_ff;
      pv_in        = 1'b0;
      x_in         = x_ff;
      sq_in        = sq_ff;
      sx_in        = sx_ff;
      sxx_in       = sxx_ff;
      sy_in        = sy_ff;
      sxy_in       = sxy_ff;
      tmp_in       = tmp_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      lim_in       = lim_ff;
      t_in         = t_ff;
      top_in       = top_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      scan_in      = scan_ff;
      hot_in       = hot_ff;
      cur_deg_in   = cur_deg_ff;
      rsp_valid_in = rsp_valid_ff;
      trend_in     = trend_ff;
      pred_in      = pred_ff;
      level_in     = level_ff;
      mul_a        = '0;
      mul_b        = '0;
      mem_wen      = 1'b0;
      mem_ren      = 1'b0;
      mem_waddr    = base + AW'(slot_ff[zone_ff]);
      mem_raddr    = base + AW'(rd_slot_ff);
      zupd         = 1'b0;
      zslot_new    = (slot_ff[zone_ff] == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff[zone_ff] + 1'b1;
      zfill_new    = (fill_ff[zone_ff] < CNT_W'(WINDOW)) ? fill_ff[zone_ff] + 1'b1
                                                         : fill_ff[zone_ff];
      zdeg_new     = '0;
      div_ctl      = '{start: 1'b0, dividend: DVD_W'(top_abs), divisor: DVS_W'(prod)};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               zone_in   = zone_ext[ZIDX_W-1:0];
               sample_in = $signed(req_sample_mdeg);
               trend_in  = TREND_STABLE;
               pred_in   = '0;
               hot_in    = '0;
               scan_in   = '0;
               if (32'(req_zone_index) < NUM_ZONES) state_in = ST_WRITE;
               else                                 state_in = ST_SCAN;
            end
         end
         ST_WRITE: begin
            mem_wen = 1'b1;
            zupd    = 1'b1;
            // divide by 1000 through the reciprocal, then saturate
            mul_a = 32'(mag);
            mul_b = 32'(RECIP_1000);
            if (sample_ff[SAMPLE_W-1])
               zdeg_new = (deg_q > 10'd256) ? 9'sh100 : DEG_W'(-$signed({1'b0, deg_q}));
            else
               zdeg_new = (deg_q > 10'd255) ? 9'sd255 : DEG_W'(deg_q);
            cur_deg_in = zdeg_new;
            n_in       = zfill_new;
            rd_slot_in = (zfill_new < CNT_W'(WINDOW)) ? '0 : zslot_new;
            rd_cnt_in  = '0;
            x_in       = '0;
            sq_in      = '0;
            sx_in      = '0;
            sxx_in     = '0;
            sy_in      = '0;
            sxy_in     = '0;
            state_in   = (zfill_new < CNT_W'(2)) ? ST_SINGLE : ST_ACC;
         end
         ST_SINGLE: begin
            mul_a = 32'(cur_deg_ff);
            mul_b = 32'(MDEG_PER_DEG);
            if (prod < 0)                    pred_in = '0;
            else if (prod > 64'(PRED_MAX))   pred_in = PRED_W'(PRED_MAX);
            else                             pred_in = PRED_W'(prod);
            state_in = ST_SCAN;
         end
         ST_ACC: begin
            if (rd_cnt_ff < n_ff) begin
               mem_ren    = 1'b1;
               rd_slot_in = (rd_slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : rd_slot_ff + 1'b1;
               rd_cnt_in  = rd_cnt_ff + 1'b1;
               pv_in      = 1'b1;
               x_in       = rd_cnt_ff;
            end
            mul_a = 32'(x_ff);
            mul_b = 32'(rd_data_ff);
            if (pv_ff) begin
               sx_in  = sx_ff + SX_W'(x_ff);
               sxx_in = sxx_ff + SXX_W'(sq_ff);
               sy_in  = sy_ff + SY_W'(rd_data_ff);
               sxy_in = sxy_ff + SXY_W'(prod);
               // (x+1)^2 = x^2 + 2x + 1
               sq_in  = sq_ff + SQ_W'({x_ff, 1'b1});
            end
            if (rd_cnt_ff == n_ff && !pv_ff) begin
               state_in = ST_MUL;
               step_in  = MS_NSXY;
            end
         end
         ST_MUL: begin
            step_in = step_ff + 1'b1;
            unique case (step_ff)
               MS_NSXY: begin
                  mul_a  = 32'(n_ff);
                  mul_b  = 32'(sxy_ff);
                  tmp_in = prod;
               end
               MS_NUM: begin
                  mul_a  = 32'(sx_ff);
                  mul_b  = 32'(sy_ff);
                  num_in = NUM_W'(tmp_ff - prod);
               end
               MS_NSXX: begin
                  mul_a  = 32'(n_ff);
                  mul_b  = 32'(sxx_ff);
                  tmp_in = prod;
               end
               MS_DEN: begin
                  mul_a  = 32'(sx_ff);
                  mul_b  = 32'(sx_ff);
                  den_in = DEN_W'(tmp_ff - prod);
               end
               MS_LIM: begin
                  mul_a  = 32'(den_ff);
                  mul_b  = 32'(SLOPE_LIMIT);
                  lim_in = NUM_W'(prod);
               end
               MS_TREND: begin
                  if (n_ff >= CNT_W'(3)) begin
                     if (num_ff > lim_ff)       trend_in = TREND_RISING;
                     else if (num_ff < -lim_ff) trend_in = TREND_FALLING;
                  end
                  mul_a = 32'(n_ff);
                  mul_b = 32'(fx);
                  t_in  = T_W'(prod - $signed(64'(sx_ff)));
               end
               MS_TOP0: begin
                  mul_a  = 32'(den_ff);
                  mul_b  = 32'(sy_ff);
                  top_in = TOP_W'(prod);
               end
               MS_TOPLO: begin
                  mul_a  = 32'(num_ff[NUM_LO-1:0]);
                  mul_b  = 32'(t_ff);
                  top_in = top_ff + TOP_W'(prod);
               end
               MS_TOPHI: begin
                  mul_a  = 32'($signed(num_ff[NUM_W-1:NUM_LO]));
                  mul_b  = 32'(t_ff);
                  top_in = top_ff + (TOP_W'(prod) <<< NUM_LO);
               end
               MS_DVS: begin
                  mul_a         = 32'(n_ff);
                  mul_b         = 32'(den_ff);
                  div_ctl.start = 1'b1;
                  neg_in        = top_ff[TOP_W-1];
                  state_in      = ST_DIV;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_DIV: begin
            if (div_sts.done) begin
               if (neg_ff)                                    pred_in = '0;
               else if (div_sts.quotient > DVD_W'(PRED_MAX))  pred_in = PRED_W'(PRED_MAX);
               else                                  pred_in = div_sts.quotient[PRED_W-1:0];
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            hot_in  = hot_new;
            scan_in = scan_ff + 1'b1;
            if (32'(scan_ff) == NUM_ZONES - 1) begin
               if ($unsigned(hot_new) >= DEG_W'(crit_ff))     level_in = LEVEL_CRITICAL;
               else if ($unsigned(hot_new) >= DEG_W'(thr_ff)) level_in = LEVEL_HOT;
               else if ($unsigned(hot_new) >= DEG_W'(warn_ff)) level_in = LEVEL_WARM;
               else                                           level_in = LEVEL_COOL;
               rsp_valid_in = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // window memory
   always_ff @(posedge clock) begin
      if (mem_wen) mem[mem_waddr] <= sample_ff;
      if (mem_ren) rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pv_ff        <= 1'b0;
         warn_ff      <= LVL_W'(70);
         thr_ff       <= LVL_W'(85);
         crit_ff      <= LVL_W'(100);
         hor_ff       <= HOR_W'(30);
         for (int z = 0; z < NUM_ZONES; z++) begin
            fill_ff[z] <= '0;
            slot_ff[z] <= '0;
            deg_ff[z]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pv_ff        <= pv_in;
         if (csr_wen) begin
            unique case (csr_index)
               REG_WARN:     warn_ff <= csr_wdata[LVL_W-1:0];
               REG_THROTTLE: thr_ff  <= csr_wdata[LVL_W-1:0];
               REG_CRITICAL: crit_ff <= csr_wdata[LVL_W-1:0];
               REG_HORIZON:  hor_ff  <= csr_wdata[HOR_W-1:0];
               default:      warn_ff <= warn_ff;
            endcase
         end
         if (zupd) begin
            fill_ff[zone_ff] <= zfill_new;
            slot_ff[zone_ff] <= zslot_new;
            deg_ff[zone_ff]  <= zdeg_new;
         end
      end
      zone_ff    <= zone_in;
      sample_ff  <= sample_in;
      n_ff       <= n_in;
      rd_slot_ff <= rd_slot_in;
      rd_cnt_ff  <= rd_cnt_in;
      x_ff       <= x_in;
      sq_ff      <= sq_in;
      sx_ff      <= sx_in;
      sxx_ff     <= sxx_in;
      sy_ff      <= sy_in;
      sxy_ff     <= sxy_in;
      tmp_ff     <= tmp_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      lim_ff     <= lim_in;
      t_ff       <= t_in;
      top_ff     <= top_in;
      neg_ff     <= neg_in;
      step_ff    <= step_in;
      scan_ff    <= scan_in;
      hot_ff     <= hot_in;
      cur_deg_ff <= cur_deg_in;
      trend_ff   <= trend_in;
      pred_ff    <= pred_in;
      level_ff   <= level_in;
   end

endmodule

>>> sim/tb_thermal_trend_predictor.sv
// tb_thermal_trend_predictor: self-checking bench for the thermal trend predictor.
// Depends on ttp_pkg and thermal_trend_predictor; drives directed then random sample
// words through several threshold and horizon settings, checked by a line-fit predictor.
`timescale 1ns / 1ps
module tb_thermal_trend_predictor;
   import ttp_pkg::*;

   localparam int  ZONES        = DEF_NUM_ZONES;
   localparam int  DEPTH        = DEF_WINDOW;
   localparam int  CYCLE_LIMIT  = 1000000;
   localparam int  DRAIN_CYCLES = 120;
   localparam int  PHASE_ITEMS  = 226;

   typedef struct packed {
      logic [1:0]        trend;
      logic [PRED_W-1:0] pred;
      logic [1:0]        level;
   } outcome_t;

   typedef struct {
      logic [1:0] zone;
      int         mdeg;
      bit         typed;
      outcome_t   want;
   } stim_row_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_zone_index = '0;
   logic [SAMPLE_W-1:0] req_sample_mdeg = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_trend;
   logic [PRED_W-1:0]   rsp_predicted_mdeg;
   logic [1:0]          rsp_overall_level;
   logic                csr_wen = 1'b0;
   logic [1:0]          csr_index = '0;
   logic [CSR_W-1:0]    csr_wdata = '0;

   // predictor state
   longint      history [ZONES][DEPTH];
   int unsigned held [ZONES];
   int unsigned next_slot [ZONES];
   longint      zone_deg [ZONES];
   logic [7:0]  warn_r, throttle_r, critical_r;
   logic [9:0]  horizon_r;

   outcome_t    pending_fits [$];
   stim_row_t   directed [$];
   int          errors = 0;
   int          cycles = 0;
   int          idle_pct = 28;

   thermal_trend_predictor DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_zone_index(req_zone_index), .req_sample_mdeg(req_sample_mdeg),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_trend(rsp_trend), .rsp_predicted_mdeg(rsp_predicted_mdeg),
      .rsp_overall_level(rsp_overall_level),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic longint clamp_mdeg(input longint v);
      return (v < 0) ? 0 : (v > PRED_MAX) ? PRED_MAX : v;
   endfunction

   // append the sample, refit the zone line and grade the hottest zone
   function automatic outcome_t fit_zone(input logic [1:0] z, input longint smp);
      longint      sx, sy, sxy, sxx, num, den, fx, top, y, d, hot, dn;
      int unsigned n, first;
      outcome_t    o;
      o = '0;
      o.trend = TREND_STABLE;
      history[z][next_slot[z]] = smp;
      next_slot[z] = (next_slot[z] + 1) % DEPTH;
      if (held[z] < DEPTH) held[z]++;
      d = smp / 1000;
      if (d > 255) d = 255;
      if (d < -256) d = -256;
      zone_deg[z] = d;
      n = held[z];
      first = (n < DEPTH) ? 0 : next_slot[z];
      if (n < 2) begin
         o.pred = PRED_W'(clamp_mdeg(d * 1000));
      end else begin
         sx = 0; sy = 0; sxy = 0; sxx = 0;
         dn = n;
         for (int i = 0; i < n; i++) begin
            y = history[z][(first + i) % DEPTH];
            sx += i;
            sy += y;
            sxy += longint'(i) * y;
            sxx += longint'(i) * i;
         end
         num = dn * sxy - sx * sy;
         den = dn * sxx - sx * sx;
         if (n >= 3) begin
            if (num > SLOPE_LIMIT * den) o.trend = TREND_RISING;
            else if (num < -SLOPE_LIMIT * den) o.trend = TREND_FALLING;
         end
         fx = dn - 1 + longint'(horizon_r);
         top = den * sy + num * (dn * fx - sx);
         o.pred = PRED_W'(clamp_mdeg(top / (dn * den)));
      end
      hot = 0;
      for (int k = 0; k < ZONES; k++)
         if (zone_deg[k] > hot) hot = zone_deg[k];
      if (hot >= longint'(critical_r)) o.level = LEVEL_CRITICAL;
      else if (hot >= longint'(throttle_r)) o.level = LEVEL_HOT;
      else if (hot >= longint'(warn_r)) o.level = LEVEL_WARM;
      else o.level = LEVEL_COOL;
      return o;
   endfunction

   always @(negedge clock)
      rsp_stall = ($urandom_range(99) < idle_pct);

   always @(posedge clock) begin
      outcome_t w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_fits.size() == 0) begin
            $display("%0t: unexpected word trend=%0d pred=%0d level=%0d", $time,
                     rsp_trend, rsp_predicted_mdeg, rsp_overall_level);
            errors++;
         end else begin
            w = pending_fits.pop_front();
            if (rsp_trend !== w.trend) begin
               $display("%0t: trend expected %0d actual %0d", $time, w.trend, rsp_trend);
               errors++;
            end
            if (rsp_predicted_mdeg !== w.pred) begin
               $display("%0t: predicted_mdeg expected %0d actual %0d", $time, w.pred,
                        rsp_predicted_mdeg);
               errors++;
            end
            if (rsp_overall_level !== w.level) begin
               $display("%0t: overall_level expected %0d actual %0d", $time, w.level,
                        rsp_overall_level);
               errors++;
            end
         end
      end
   end

   task automatic send_sample(input logic [1:0] z, input int mdeg, input bit typed,
                              input outcome_t want);
      outcome_t got;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_zone_index = z;
      req_sample_mdeg = mdeg[SAMPLE_W-1:0];
      do @(posedge clock); while (req_stall);
      got = fit_zone(z, longint'(mdeg));
      pending_fits = {pending_fits, (typed ? want : got)};
   endtask

   task automatic write_reg(input logic [1:0] idx, input int value);
      @(negedge clock);
      req_valid = 1'b0;
      csr_wen = 1'b1;
      csr_index = idx;
      csr_wdata = value[CSR_W-1:0];
      case (idx)
         REG_WARN:     warn_r = value[7:0];
         REG_THROTTLE: throttle_r = value[7:0];
         REG_CRITICAL: critical_r = value[7:0];
         REG_HORIZON:  horizon_r = value[9:0];
      endcase
      @(negedge clock);
      csr_wen = 1'b0;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      wait (pending_fits.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void add_row(input logic [1:0] z, input int mdeg, input bit typed,
                                   input outcome_t want);
      stim_row_t r;
      r.zone = z; r.mdeg = mdeg; r.typed = typed; r.want = want;
      directed = {directed, r};
   endfunction

   initial begin
      int base [ZONES];
      int slope [ZONES];
      int lvl [3];
      int s, z;
      for (int k = 0; k < ZONES; k++) begin
         held[k] = 0; next_slot[k] = 0; zone_deg[k] = 0;
      end
      warn_r = 70; throttle_r = 85; critical_r = 100; horizon_r = 30;

      // first rows follow straight from reset values
      add_row(0, 150000, 1, '{TREND_STABLE, 18'd150000, LEVEL_CRITICAL});
      add_row(1, -55000, 1, '{TREND_STABLE, 18'd0, LEVEL_CRITICAL});
      add_row(0, 120000, 0, '0);
      add_row(0, 90000, 0, '0);
      add_row(0, 60000, 0, '0);
      add_row(2, 30000, 0, '0);
      add_row(2, 31000, 0, '0);
      add_row(2, 33000, 0, '0);
      add_row(2, 36000, 0, '0);
      add_row(3, 45000, 0, '0);
      add_row(3, 45000, 0, '0);
      add_row(3, 45050, 0, '0);
      add_row(1, -55000, 0, '0);
      add_row(1, -1, 0, '0);
      add_row(1, -999, 0, '0);
      add_row(1, 150000, 0, '0);
      add_row(3, 0, 0, '0);
      add_row(2, 999, 0, '0);
      add_row(0, 131071, 0, '0);
      add_row(0, 100000, 0, '0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         send_sample(directed[i].zone, directed[i].mdeg, directed[i].typed, directed[i].want);

      for (int phase = 0; phase < 5; phase++) begin
         settle();
         case (phase)
            0: begin lvl = '{70, 85, 100}; s = 30; end
            1: begin lvl = '{0, 0, 0}; s = 0; end
            2: begin lvl = '{200, 200, 200}; s = 1023; end
            3: begin
               lvl = '{$urandom_range(200), $urandom_range(200), $urandom_range(200)};
               s = $urandom_range(1023);
            end
            default: begin lvl = '{40, 60, 80}; s = 1; end
         endcase
         write_reg(REG_WARN, lvl[0]);
         write_reg(REG_THROTTLE, lvl[1]);
         write_reg(REG_CRITICAL, lvl[2]);
         write_reg(REG_HORIZON, s);
         idle_pct = (phase == 2) ? 0 : 28;
         for (int k = 0; k < ZONES; k++) begin
            base[k] = $urandom_range(150000) - 20000;
            slope[k] = $urandom_range(6000) - 3000;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            z = $urandom_range(ZONES - 1);
            if ($urandom_range(99) < 85) begin
               // steady ramp with small jitter, turning back at the range ends
               base[z] += slope[z];
               if (base[z] > 150000 || base[z] < -55000) begin
                  slope[z] = -slope[z];
                  base[z] = (base[z] > 150000) ? 150000 : -55000;
               end
               if ($urandom_range(19) == 0) slope[z] = $urandom_range(6000) - 3000;
               s = base[z] + $urandom_range(400) - 200;
               if (s > 150000) s = 150000;
               if (s < -55000) s = -55000;
            end else begin
               s = $urandom_range(205000) - 55000;
            end
            send_sample(z[1:0], s, 0, '0);
         end
      end

      settle();
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> filelist.f
hdl/ttp_pkg.sv
hdl/ttp_div.sv
hdl/thermal_trend_predictor.sv
sim/tb_thermal_trend_predictor.sv
